@@ hdl/edwa_pkg.sv @@
`timescale 1ns / 1ps

package edwa_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int INDEX_BITS  = 20;
	localparam int AREA_BITS   = 40;

	// result queue between front and back
	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = $clog2(QDEPTH);
	localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

	localparam logic [INDEX_BITS-1:0] IDX_MAX  = {INDEX_BITS{1'b1}};
	localparam logic [AREA_BITS-1:0]  AREA_MAX = {1'b0, {(AREA_BITS-1){1'b1}}};
	localparam logic [AREA_BITS-1:0]  AREA_MIN = {1'b1, {(AREA_BITS-1){1'b0}}};

	// one output word
	typedef struct packed {
		logic [INDEX_BITS-1:0]         peak_index;
		logic signed [SAMPLE_BITS-1:0] peak_value;
		logic signed [AREA_BITS-1:0]   area_twice;
		logic                          is_maximum;
		logic                          is_sentinel;
		logic                          trace_done;
		logic                          run_last;
		logic                          too_short;
		logic                          overflowed;
	} peak_rec_t;

	// all words caused by one sample
	typedef struct packed {
		logic      two;
		peak_rec_t r1;
		peak_rec_t r0;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ hdl/edwa_smp_if.sv @@
`timescale 1ns / 1ps

interface edwa_smp_if;
	import edwa_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          is_last;

	modport source (output valid, output sample, output is_last, input ready);
	modport sink (input valid, input sample, input is_last, output ready);
endinterface

@@ hdl/edwa_peak_if.sv @@
`timescale 1ns / 1ps

interface edwa_peak_if;
	import edwa_pkg::*;

	logic                          valid;
	logic                          ready;
	logic [INDEX_BITS-1:0]         peak_index;
	logic signed [SAMPLE_BITS-1:0] peak_value;
	logic signed [AREA_BITS-1:0]   area_twice;
	logic                          is_maximum;
	logic                          is_sentinel;
	logic                          trace_done;
	logic                          run_last;
	logic                          too_short;
	logic                          overflowed;

	modport source (
		output valid, output peak_index, output peak_value, output area_twice,
		output is_maximum, output is_sentinel, output trace_done, output run_last,
		output too_short, output overflowed, input ready
	);
	modport sink (
		input valid, input peak_index, input peak_value, input area_twice,
		input is_maximum, input is_sentinel, input trace_done, input run_last,
		input too_short, input overflowed, output ready
	);
endinterface

@@ hdl/edwa_front.sv @@
`timescale 1ns / 1ps

module edwa_front (
	input  logic               clk,
	input  logic               arst_n,
	edwa_smp_if.sink           samples,
	input  edwa_pkg::q_stat_t  q_stat,
	output logic               push,
	output edwa_pkg::q_entry_t push_data
);
	import edwa_pkg::*;

	typedef enum logic [1:0] {TR_NONE, TR_UP, TR_DOWN} trend_t;

	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic signed [SAMPLE_BITS-1:0] first_q;
	trend_t                        trend_q;
	logic [INDEX_BITS-1:0]         count_q;
	logic signed [AREA_BITS-1:0]   area_q;
	logic                          head_sent_q;
	logic                          last_max_q;
	logic                          ovf_q;
	logic                          idx_full_q;

	logic                          accept;
	logic                          start;
	logic signed [SAMPLE_BITS-1:0] x;
	logic                          is_last;
	logic [INDEX_BITS-1:0]         pidx;
	logic signed [AREA_BITS:0]     sum_w;
	logic signed [AREA_BITS-1:0]   sum_sat;
	logic                          sat;
	logic                          ovf_n;
	logic                          diff;
	logic                          rising;
	logic                          has_a;
	logic                          has_b;
	logic                          lm_a;
	peak_rec_t                     rec_a;
	peak_rec_t                     rec_b;
	peak_rec_t                     rec_c;
	peak_rec_t                     rec_short;

	function automatic peak_rec_t mk_rec(
		input logic [INDEX_BITS-1:0]         idx,
		input logic signed [SAMPLE_BITS-1:0] val,
		input logic signed [AREA_BITS-1:0]   area,
		input logic                          mx,
		input logic                          sent
	);
		peak_rec_t r;
		r = '0;
		r.peak_index  = idx;
		r.peak_value  = val;
		r.area_twice  = area;
		r.is_maximum  = mx;
		r.is_sentinel = sent;
		return r;
	endfunction

	assign samples.ready = !q_stat.full;
	assign accept        = samples.valid && samples.ready;
	assign x             = samples.sample;
	assign is_last       = samples.is_last;
	assign start         = (count_q == '0) && !idx_full_q;

	// running area, saturated to the signed range
	always_comb begin
		sum_w = {area_q[AREA_BITS-1], area_q}
			+ {{(AREA_BITS+1-SAMPLE_BITS){prev_q[SAMPLE_BITS-1]}}, prev_q}
			+ {{(AREA_BITS+1-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
		sat = sum_w[AREA_BITS] != sum_w[AREA_BITS-1];
		if (!sat) begin
			sum_sat = sum_w[AREA_BITS-1:0];
		end else if (sum_w[AREA_BITS]) begin
			sum_sat = AREA_MIN;
		end else begin
			sum_sat = AREA_MAX;
		end
		ovf_n = ovf_q || idx_full_q || sat;
		pidx  = idx_full_q ? IDX_MAX : count_q - INDEX_BITS'(1);
	end

	// classify the sample against the previous one
	always_comb begin
		diff   = x != prev_q;
		rising = x > prev_q;
		has_a  = 1'b0;
		lm_a   = last_max_q;
		rec_a  = '0;
		if (diff) begin
			if (!head_sent_q) begin
				has_a = 1'b1;
				lm_a  = x < first_q;
				rec_a = mk_rec('0, first_q, '0, x < first_q, 1'b1);
			end else if (trend_q == TR_UP && !rising) begin
				has_a = 1'b1;
				lm_a  = 1'b1;
				rec_a = mk_rec(pidx, prev_q, area_q, 1'b1, 1'b0);
			end else if (trend_q == TR_DOWN && rising) begin
				has_a = 1'b1;
				lm_a  = 1'b0;
				rec_a = mk_rec(pidx, prev_q, area_q, 1'b0, 1'b0);
			end
		end
		// all-flat trace: leading sentinel falls back to a minimum
		has_b = !head_sent_q && !diff;
		rec_b = mk_rec('0, first_q, '0, 1'b0, 1'b1);
		rec_c = mk_rec(count_q, x, sum_sat, has_b ? 1'b1 : !lm_a, 1'b1);
		rec_a.overflowed = ovf_n;
		rec_b.overflowed = ovf_n;
		rec_c.overflowed = ovf_n;
		rec_c.run_last   = 1'b1;
		rec_c.trace_done = 1'b1;
		rec_short            = '0;
		rec_short.too_short  = 1'b1;
		rec_short.trace_done = 1'b1;
		rec_short.run_last   = 1'b1;
	end

	// pack the words of this sample for the queue
	always_comb begin
		push_data = '0;
		push      = 1'b0;
		if (start) begin
			push         = accept && is_last;
			push_data.r0 = rec_short;
		end else if (is_last) begin
			push          = accept;
			push_data.two = has_a || has_b;
			push_data.r0  = has_b ? rec_b : (has_a ? rec_a : rec_c);
			push_data.r1  = rec_c;
		end else begin
			push                  = accept && has_a;
			push_data.r0          = rec_a;
			push_data.r0.run_last = 1'b1;
		end
	end

	// trace state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			first_q     <= '0;
			trend_q     <= TR_NONE;
			count_q     <= '0;
			area_q      <= '0;
			head_sent_q <= 1'b0;
			last_max_q  <= 1'b0;
			ovf_q       <= 1'b0;
			idx_full_q  <= 1'b0;
		end else if (accept) begin
			if (is_last) begin
				prev_q      <= '0;
				first_q     <= '0;
				trend_q     <= TR_NONE;
				count_q     <= '0;
				area_q      <= '0;
				head_sent_q <= 1'b0;
				last_max_q  <= 1'b0;
				ovf_q       <= 1'b0;
				idx_full_q  <= 1'b0;
			end else if (start) begin
				first_q <= x;
				prev_q  <= x;
				count_q <= INDEX_BITS'(1);
			end else begin
				prev_q     <= x;
				area_q     <= sum_sat;
				ovf_q      <= ovf_n;
				last_max_q <= lm_a;
				if (diff) begin
					head_sent_q <= 1'b1;
					trend_q     <= rising ? TR_UP : TR_DOWN;
				end
				if (count_q != IDX_MAX) begin
					count_q <= count_q + INDEX_BITS'(1);
				end else begin
					idx_full_q <= 1'b1;
				end
			end
		end
	end

`ifndef SYNTH
	a_fresh_trace: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 && !idx_full_q) |-> (!head_sent_q && trend_q == TR_NONE))
		else $error("trace state not clean before first sample");
	a_head_trend: assert property (@(posedge clk) disable iff (!arst_n)
		head_sent_q == (trend_q != TR_NONE))
		else $error("leading sentinel flag out of step with trend");
`endif

endmodule

@@ hdl/edwa_queue.sv @@
`timescale 1ns / 1ps

module edwa_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  edwa_pkg::q_entry_t push_data,
	input  logic               pop,
	output edwa_pkg::q_entry_t pop_data,
	output edwa_pkg::q_stat_t  stat
);
	import edwa_pkg::*;

	q_entry_t               mem_q [QDEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q;
	logic [QPTR_BITS-1:0]   rd_ptr_q;
	logic [QCNT_BITS-1:0]   cnt_q;

	function automatic logic [QPTR_BITS-1:0] ptr_next(input logic [QPTR_BITS-1:0] p);
		return (p == QPTR_BITS'(QDEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
	endfunction

	assign stat.full  = cnt_q == QCNT_BITS'(QDEPTH);
	assign stat.empty = cnt_q == '0;
	assign pop_data   = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_BITS'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_BITS'(1);
			end
		end
	end

`ifndef SYNTH
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("push into full queue");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("pop from empty queue");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_BITS'(QDEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

@@ hdl/edwa_back.sv @@
`timescale 1ns / 1ps

module edwa_back (
	input  logic               clk,
	input  logic               arst_n,
	input  edwa_pkg::q_entry_t pop_data,
	input  edwa_pkg::q_stat_t  q_stat,
	output logic               pop,
	edwa_peak_if.source        peaks
);
	import edwa_pkg::*;

	logic      out_valid_q;
	logic      sel_q;
	peak_rec_t rec_q;
	logic      load;

	// output register takes a new word when empty or being drained
	assign load = !out_valid_q || peaks.ready;
	assign pop  = load && !q_stat.empty && (sel_q || !pop_data.two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
		end else if (load) begin
			out_valid_q <= !q_stat.empty;
			if (!q_stat.empty) begin
				sel_q <= !sel_q && pop_data.two;
			end
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (load && !q_stat.empty) begin
			rec_q <= sel_q ? pop_data.r1 : pop_data.r0;
		end
	end

	assign peaks.valid       = out_valid_q;
	assign peaks.peak_index  = rec_q.peak_index;
	assign peaks.peak_value  = rec_q.peak_value;
	assign peaks.area_twice  = rec_q.area_twice;
	assign peaks.is_maximum  = rec_q.is_maximum;
	assign peaks.is_sentinel = rec_q.is_sentinel;
	assign peaks.trace_done  = rec_q.trace_done;
	assign peaks.run_last    = rec_q.run_last;
	assign peaks.too_short   = rec_q.too_short;
	assign peaks.overflowed  = rec_q.overflowed;

`ifndef SYNTH
	a_second_word: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> (out_valid_q && !q_stat.empty))
		else $error("second word pending without its entry");
`endif

endmodule

@@ hdl/extremum_detector_with_area.sv @@
`timescale 1ns / 1ps

// Local extremum detector with running trapezoidal area. Takes one trace sample per
// cycle on samples and reports maxima, minima and the leading and trailing sentinels on
// peaks, each with its index, value and twice the area from sample 0. A sample is
// accepted every cycle while the four-entry result queue has room; a result word passes
// through that queue and then the output register. The last sample of a trace may
// give two words, which leave one after the other, so the sustained rate is one sample
// per cycle and the output port limits it only when the queue fills under backpressure.

module extremum_detector_with_area (
	input logic         clk,
	input logic         arst_n,
	edwa_smp_if.sink    samples,
	edwa_peak_if.source peaks
);
	import edwa_pkg::*;

	logic     push;
	logic     pop;
	q_entry_t push_data;
	q_entry_t pop_data;
	q_stat_t  q_stat;

	edwa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	edwa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	edwa_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_data (pop_data),
		.q_stat   (q_stat),
		.pop      (pop),
		.peaks    (peaks)
	);

endmodule

@@ test/extremum_detector_with_area_tb.sv @@
`timescale 1ns / 1ps

module extremum_detector_with_area_tb;
	import edwa_pkg::*;

	localparam int          CYCLE_LIMIT = 6_000_000;
	localparam int          DRAIN_WAIT  = 20;
	localparam longint      AREA_HI     = (longint'(1) <<< (AREA_BITS - 1)) - 1;
	localparam longint      AREA_LO     = -AREA_HI - 1;
	localparam int          SMP_HI      = (1 <<< (SAMPLE_BITS - 1)) - 1;
	localparam int          SMP_LO      = -SMP_HI - 1;

	typedef enum logic [1:0] {SLOPE_NONE, SLOPE_UP, SLOPE_DOWN} slope_t;

	logic clk;
	logic arst_n;

	edwa_smp_if  smp ();
	edwa_peak_if pk ();

	extremum_detector_with_area u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(smp),
		.peaks  (pk)
	);

	// tracker of the detector state
	logic signed [SAMPLE_BITS-1:0] last_smp;
	logic signed [SAMPLE_BITS-1:0] head_val;
	slope_t                        slope;
	logic [INDEX_BITS-1:0]         next_idx;
	logic                          idx_pinned;
	logic signed [AREA_BITS-1:0]   area_acc;
	logic                          head_done;
	logic                          prev_was_max;
	logic                          ovf_seen;

	peak_rec_t pending_peaks[$];

	int          err_cnt;
	int          hold_left;
	bit          tx_idle;
	bit          rx_idle;
	int unsigned cyc_cnt;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin : watchdog
		cyc_cnt = 0;
		while (cyc_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc_cnt++;
		end
		$display("simulation failed");
		$finish;
	end

	function automatic void clear_track();
		last_smp     = '0;
		head_val     = '0;
		slope        = SLOPE_NONE;
		next_idx     = '0;
		idx_pinned   = 1'b0;
		area_acc     = '0;
		head_done    = 1'b0;
		prev_was_max = 1'b0;
		ovf_seen     = 1'b0;
	endfunction

	function automatic peak_rec_t mk_peak(input logic [INDEX_BITS-1:0] idx,
			input logic signed [SAMPLE_BITS-1:0] v, input logic signed [AREA_BITS-1:0] a,
			input logic mx, input logic snt);
		peak_rec_t p;
		p             = '0;
		p.peak_index  = idx;
		p.peak_value  = v;
		p.area_twice  = a;
		p.is_maximum  = mx;
		p.is_sentinel = snt;
		return p;
	endfunction

	// peaks caused by one sample, appended to the pending list
	function automatic void trace_peaks(input logic signed [SAMPLE_BITS-1:0] x,
			input logic last);
		peak_rec_t                   found[$];
		peak_rec_t                   p;
		logic [INDEX_BITS-1:0]       pidx;
		logic signed [AREA_BITS-1:0] area_before;
		longint                      sum;
		logic                        mx;

		// first sample of a trace
		if (next_idx == 0 && !idx_pinned) begin
			if (last) begin
				p            = '0;
				p.trace_done = 1'b1;
				p.run_last   = 1'b1;
				p.too_short  = 1'b1;
				pending_peaks.push_back(p);
				clear_track();
			end else begin
				head_val = x;
				last_smp = x;
				next_idx = INDEX_BITS'(1);
			end
			return;
		end

		if (idx_pinned) begin
			ovf_seen = 1'b1;
			pidx     = IDX_MAX;
		end else begin
			pidx = next_idx - 1'b1;
		end

		// running area with clamp
		area_before = area_acc;
		sum = longint'(area_acc) + longint'(last_smp) + longint'(x);
		if (sum > AREA_HI) begin
			sum      = AREA_HI;
			ovf_seen = 1'b1;
		end else if (sum < AREA_LO) begin
			sum      = AREA_LO;
			ovf_seen = 1'b1;
		end
		area_acc = sum[AREA_BITS-1:0];

		// direction change
		if (x != last_smp) begin
			if (!head_done) begin
				mx = (x < head_val);
				found.push_back(mk_peak('0, head_val, '0, mx, 1'b1));
				head_done    = 1'b1;
				prev_was_max = mx;
			end else if (slope == SLOPE_UP && x < last_smp) begin
				found.push_back(mk_peak(pidx, last_smp, area_before, 1'b1, 1'b0));
				prev_was_max = 1'b1;
			end else if (slope == SLOPE_DOWN && x > last_smp) begin
				found.push_back(mk_peak(pidx, last_smp, area_before, 1'b0, 1'b0));
				prev_was_max = 1'b0;
			end
			slope = (x > last_smp) ? SLOPE_UP : SLOPE_DOWN;
		end

		// trailing sentinel, with the leading one for a flat trace
		if (last) begin
			if (!head_done) begin
				found.push_back(mk_peak('0, head_val, '0, 1'b0, 1'b1));
				prev_was_max = 1'b0;
			end
			found.push_back(mk_peak(next_idx, x, area_acc, !prev_was_max, 1'b1));
		end

		foreach (found[k])
			found[k].overflowed = ovf_seen;
		if (found.size() > 0) begin
			found[found.size()-1].run_last   = 1'b1;
			found[found.size()-1].trace_done = last;
		end
		foreach (found[k])
			pending_peaks.push_back(found[k]);

		if (last) begin
			clear_track();
		end else begin
			last_smp = x;
			if (next_idx < IDX_MAX)
				next_idx++;
			else
				idx_pinned = 1'b1;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		if (!tx_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(15, 40);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input int mode,
			input logic signed [SAMPLE_BITS-1:0] prev);
		logic [SAMPLE_BITS-1:0] raw;
		int                     v;
		int                     d;
		raw = SAMPLE_BITS'($urandom);
		v   = int'(prev);
		case (mode)
			0: begin
				v = int'($signed(raw));
			end
			1: begin
				// small steps, plateaus common
				if ($urandom_range(0, 2) != 0) begin
					d = $urandom_range(0, 6);
					v = v + d - 3;
				end
			end
			2: begin
				if ($urandom_range(0, 3) != 0) begin
					d = $urandom_range(0, 8000);
					v = v + d - 4000;
				end
			end
			default: begin
				// hug the rails
				case ($urandom_range(0, 4))
					0: v = SMP_LO;
					1: v = SMP_LO + 1;
					2: v = SMP_HI - 1;
					3: v = SMP_HI;
					default: ;
				endcase
			end
		endcase
		if (v > SMP_HI)
			v = SMP_HI;
		if (v < SMP_LO)
			v = SMP_LO;
		return v[SAMPLE_BITS-1:0];
	endfunction

	// offer one sample word and wait for it to be taken
	task automatic send_word(input logic signed [SAMPLE_BITS-1:0] x, input logic last,
			input int gap);
		if (gap > 0) begin
			smp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp.valid   <= 1'b1;
		smp.sample  <= x;
		smp.is_last <= last;
		trace_peaks(x, last);
		do
			@(posedge clk);
		while (!smp.ready);
	endtask

	// stop offering and wait for every expected word
	task automatic wait_drained();
		smp.valid <= 1'b0;
		@(posedge clk);
		while (pending_peaks.size() != 0)
			@(posedge clk);
	endtask

	// result side: random stalls, long hold on request, and checking
	initial begin : rx_side
		int        stall_left;
		int        run_left;
		int        r;
		peak_rec_t got;
		peak_rec_t want;
		stall_left = 0;
		run_left   = 0;
		pk.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pk.valid && pk.ready) begin
				got             = '0;
				got.peak_index  = pk.peak_index;
				got.peak_value  = pk.peak_value;
				got.area_twice  = pk.area_twice;
				got.is_maximum  = pk.is_maximum;
				got.is_sentinel = pk.is_sentinel;
				got.trace_done  = pk.trace_done;
				got.run_last    = pk.run_last;
				got.too_short   = pk.too_short;
				got.overflowed  = pk.overflowed;
				if (pending_peaks.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("stray peak word: idx %0d val %0d area %0d",
							got.peak_index, got.peak_value, got.area_twice);
				end else begin
					want = pending_peaks.pop_front();
					if (got !== want) begin
						err_cnt++;
						if (err_cnt <= 10) begin
							$display("peak mismatch exp: idx %0d val %0d area %0d flags %b%b%b%b%b%b",
								want.peak_index, want.peak_value, want.area_twice,
								want.is_maximum, want.is_sentinel, want.trace_done,
								want.run_last, want.too_short, want.overflowed);
							$display("peak mismatch got: idx %0d val %0d area %0d flags %b%b%b%b%b%b",
								got.peak_index, got.peak_value, got.area_twice,
								got.is_maximum, got.is_sentinel, got.trace_done,
								got.run_last, got.too_short, got.overflowed);
						end
					end
				end
			end
			if (hold_left > 0) begin
				pk.ready <= 1'b0;
				hold_left--;
			end else if (!rx_idle) begin
				pk.ready <= 1'b1;
			end else begin
				if (stall_left == 0 && run_left == 0) begin
					r = $urandom_range(0, 99);
					if (r < 60)
						run_left = $urandom_range(1, 8);
					else if (r < 92)
						stall_left = $urandom_range(1, 3);
					else
						stall_left = $urandom_range(15, 40);
				end
				if (stall_left > 0) begin
					pk.ready <= 1'b0;
					stall_left--;
				end else begin
					pk.ready <= 1'b1;
					run_left--;
				end
			end
		end
	end

	// extremes, short traces, flat traces and plateaus
	task automatic test_directed();
		int   vals[24] = '{32767, -32768, 5, 5, 5, -32768, 32767, 32767, -32768,
			0, 100, 100, 100, -100, -100, 50, 1, 2, 2, 4, 4, 4, -1, 3};
		bit   ends[24] = '{1, 1, 0, 0, 1, 0, 1, 0, 1,
			0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0, 0, 0, 0, 1};
		logic signed [SAMPLE_BITS-1:0] x;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		for (int k = 0; k < 24; k++) begin
			x = vals[k][SAMPLE_BITS-1:0];
			send_word(x, ends[k], pick_gap());
		end
		wait_drained();
	endtask

	// random traces of mixed shape and length
	task automatic test_random_traces(input int n_words);
		int                            sent;
		int                            len;
		int                            mode;
		int                            r;
		logic signed [SAMPLE_BITS-1:0] x;
		sent = 0;
		while (sent < n_words) begin
			r = $urandom_range(0, 99);
			if (r < 5)
				len = 1;
			else if (r < 80)
				len = $urandom_range(2, 24);
			else
				len = $urandom_range(25, 80);
			mode    = $urandom_range(0, 3);
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			x = pick_sample(0, '0);
			for (int k = 0; k < len; k++) begin
				if (k > 0)
					x = pick_sample(mode, x);
				send_word(x, k == len - 1, pick_gap());
			end
			sent += len;
		end
		wait_drained();
	endtask

	// long output hold while a zigzag trace keeps coming
	task automatic test_output_stall();
		int                            v;
		logic signed [SAMPLE_BITS-1:0] x;
		tx_idle   = 1'b0;
		rx_idle   = 1'b1;
		hold_left = 300;
		for (int k = 0; k < 40; k++) begin
			v = (k % 2) ? 1000 + k : -1000 - k;
			x = v[SAMPLE_BITS-1:0];
			send_word(x, k == 39, 0);
		end
		wait_drained();
	endtask

	initial begin : main
		err_cnt   = 0;
		hold_left = 0;
		tx_idle   = 1'b1;
		rx_idle   = 1'b1;
		clear_track();
		arst_n      <= 1'b0;
		smp.valid   <= 1'b0;
		smp.sample  <= '0;
		smp.is_last <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_traces(1830);
		test_output_stall();

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_cnt == 0 && pending_peaks.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
